@@ rtl/json_string_unescape_utf8_unit_defines.svh @@
// Assertion macros shared by the unescaper modules.
`ifndef JSON_STRING_UNESCAPE_UTF8_UNIT_DEFINES_SVH
`define JSON_STRING_UNESCAPE_UTF8_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define JSU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define JSU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define JSU_ASSERT(lbl, prop, msg)
`define JSU_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ rtl/jsu_pkg.sv @@
package jsu_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_req_t;

  typedef enum logic [2:0] {
    ST_BYTE   = 3'd0,
    ST_DONE   = 3'd1,
    ST_UNTERM = 3'd2,
    ST_BADESC = 3'd3,
    ST_BADU   = 3'd4,
    ST_CTRL   = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0] out_byte;
    status_t    status;
    logic       last;
  } out_req_t;

  // Work list for one request: a first run of up to four UTF-8 bytes, a
  // second run of up to three, then an optional status result.
  typedef struct packed {
    logic [3:0][7:0] a_bytes;
    logic [2:0]      a_len;
    logic [2:0][7:0] b_bytes;
    logic [1:0]      b_len;
    logic            has_status;
    status_t         status;
  } cmd_t;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      len;
  } utf8_t;

  localparam logic [15:0] SURR_HI_MIN = 16'hD800;
  localparam logic [15:0] SURR_HI_MAX = 16'hDBFF;
  localparam logic [15:0] SURR_LO_MIN = 16'hDC00;
  localparam logic [15:0] SURR_LO_MAX = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE   = 21'h10000;
  localparam logic [7:0]  CTRL_LIMIT  = 8'h20;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  localparam logic [7:0] CC_BS  = 8'h08;
  localparam logic [7:0] CC_FF  = 8'h0C;
  localparam logic [7:0] CC_LF  = 8'h0A;
  localparam logic [7:0] CC_CR  = 8'h0D;
  localparam logic [7:0] CC_TAB = 8'h09;

  function automatic utf8_t utf8_encode(input logic [20:0] v);
    utf8_t r;
    r = '0;
    if (v < 21'h80) begin
      r.bytes[0] = v[7:0];
      r.len      = 3'd1;
    end else if (v < 21'h800) begin
      r.bytes[0] = {3'b110, v[10:6]};
      r.bytes[1] = {2'b10, v[5:0]};
      r.len      = 3'd2;
    end else if (v < 21'h10000) begin
      r.bytes[0] = {4'b1110, v[15:12]};
      r.bytes[1] = {2'b10, v[11:6]};
      r.bytes[2] = {2'b10, v[5:0]};
      r.len      = 3'd3;
    end else begin
      r.bytes[0] = {5'b11110, v[20:18]};
      r.bytes[1] = {2'b10, v[17:12]};
      r.bytes[2] = {2'b10, v[11:6]};
      r.bytes[3] = {2'b10, v[5:0]};
      r.len      = 3'd4;
    end
    return r;
  endfunction

  // Returns a valid flag above the four-bit digit value.
  function automatic logic [4:0] hex_decode(input logic [7:0] b);
    logic [7:0] d;
    d = 8'd0;
    if (b inside {[8'h30:8'h39]}) begin
      d = b - 8'h30;
      return {1'b1, d[3:0]};
    end else if (b inside {[8'h61:8'h66]}) begin
      d = b - 8'h57;
      return {1'b1, d[3:0]};
    end else if (b inside {[8'h41:8'h46]}) begin
      d = b - 8'h37;
      return {1'b1, d[3:0]};
    end
    return 5'd0;
  endfunction

endpackage

@@ rtl/jsu_front.sv @@
`include "json_string_unescape_utf8_unit_defines.svh"

module jsu_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  jsu_pkg::in_req_t in_data,
  output logic             in_ready,
  input  logic             q_full,
  output logic             push,
  output jsu_pkg::cmd_t    cmd
);

  typedef enum logic [5:0] {
    M_PLAIN   = 6'b000001,
    M_ESC     = 6'b000010,
    M_HEX1    = 6'b000100,
    M_HIGH    = 6'b001000,
    M_HIGH_BS = 6'b010000,
    M_HEX2    = 6'b100000
  } mode_t;

  mode_t       mode_r, mode_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [15:0] first_r, first_nxt;
  logic [15:0] second_r, second_nxt;

  logic [7:0]  b;
  logic        accept;
  logic [4:0]  hx;
  logic [15:0] acc1, acc2;
  logic [20:0] joined;
  logic        acc1_high, acc2_high, acc2_low;
  logic        clr;
  jsu_pkg::utf8_t enc_first, enc_acc1, enc_acc2, enc_join;
  jsu_pkg::cmd_t  c;

  logic             p_status_v, p_to_esc;
  jsu_pkg::status_t p_status;
  logic             e_byte_v, e_to_hex;
  logic [7:0]       e_byte;

  assign b        = in_data.in_byte;
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  assign hx        = jsu_pkg::hex_decode(b);
  assign acc1      = {first_r[11:0], hx[3:0]};
  assign acc2      = {second_r[11:0], hx[3:0]};
  assign joined    = jsu_pkg::SUPP_BASE + {1'b0, first_r[9:0], acc2[9:0]};
  assign acc1_high = (acc1 >= jsu_pkg::SURR_HI_MIN) && (acc1 <= jsu_pkg::SURR_HI_MAX);
  assign acc2_high = (acc2 >= jsu_pkg::SURR_HI_MIN) && (acc2 <= jsu_pkg::SURR_HI_MAX);
  assign acc2_low  = (acc2 >= jsu_pkg::SURR_LO_MIN) && (acc2 <= jsu_pkg::SURR_LO_MAX);
  assign enc_first = jsu_pkg::utf8_encode({5'd0, first_r});
  assign enc_acc1  = jsu_pkg::utf8_encode({5'd0, acc1});
  assign enc_acc2  = jsu_pkg::utf8_encode({5'd0, acc2});
  assign enc_join  = jsu_pkg::utf8_encode(joined);

  always_comb begin
    p_status_v = 1'b0;
    p_status   = jsu_pkg::ST_DONE;
    p_to_esc   = 1'b0;
    if (b == jsu_pkg::CH_QUOTE) begin
      p_status_v = 1'b1;
    end else if (b == jsu_pkg::CH_BSLASH) begin
      p_to_esc = 1'b1;
    end else if (b < jsu_pkg::CTRL_LIMIT) begin
      p_status_v = 1'b1;
      p_status   = jsu_pkg::ST_CTRL;
    end
  end

  always_comb begin
    e_byte_v = 1'b1;
    e_byte   = b;
    e_to_hex = 1'b0;
    case (b)
      jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH: e_byte = b;
      jsu_pkg::CH_B: e_byte = jsu_pkg::CC_BS;
      jsu_pkg::CH_F: e_byte = jsu_pkg::CC_FF;
      jsu_pkg::CH_N: e_byte = jsu_pkg::CC_LF;
      jsu_pkg::CH_R: e_byte = jsu_pkg::CC_CR;
      jsu_pkg::CH_T: e_byte = jsu_pkg::CC_TAB;
      jsu_pkg::CH_U: begin
        e_byte_v = 1'b0;
        e_to_hex = 1'b1;
      end
      default: e_byte_v = 1'b0;
    endcase
  end

  always_comb begin
    mode_nxt   = mode_r;
    cnt_nxt    = cnt_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    clr        = 1'b0;
    c          = '0;
    c.status   = jsu_pkg::ST_BYTE;
    if (in_data.end_of_input) begin
      clr          = 1'b1;
      c.has_status = 1'b1;
      case (mode_r)
        M_HEX1: c.status = jsu_pkg::ST_BADU;
        M_HIGH, M_HIGH_BS: begin
          c.a_bytes = enc_first.bytes;
          c.a_len   = enc_first.len;
          c.status  = jsu_pkg::ST_UNTERM;
        end
        M_HEX2: begin
          c.a_bytes = enc_first.bytes;
          c.a_len   = enc_first.len;
          c.status  = jsu_pkg::ST_BADU;
        end
        default: c.status = jsu_pkg::ST_UNTERM;
      endcase
    end else begin
      case (mode_r)
        M_ESC: begin
          mode_nxt = M_PLAIN;
          if (e_to_hex) begin
            mode_nxt  = M_HEX1;
            cnt_nxt   = 2'd0;
            first_nxt = 16'd0;
          end else if (e_byte_v) begin
            c.a_bytes[0] = e_byte;
            c.a_len      = 3'd1;
          end else begin
            c.has_status = 1'b1;
            c.status     = jsu_pkg::ST_BADESC;
            clr          = 1'b1;
          end
        end
        M_HEX1: begin
          if (!hx[4]) begin
            c.has_status = 1'b1;
            c.status     = jsu_pkg::ST_BADU;
            clr          = 1'b1;
          end else if (cnt_r == 2'd3) begin
            if (acc1_high) begin
              first_nxt  = acc1;
              mode_nxt   = M_HIGH;
              cnt_nxt    = 2'd0;
              second_nxt = 16'd0;
            end else begin
              c.a_bytes = enc_acc1.bytes;
              c.a_len   = enc_acc1.len;
              clr       = 1'b1;
            end
          end else begin
            first_nxt = acc1;
            cnt_nxt   = cnt_r + 2'd1;
          end
        end
        M_HIGH: begin
          if (b == jsu_pkg::CH_BSLASH) begin
            mode_nxt = M_HIGH_BS;
          end else begin
            c.a_bytes = enc_first.bytes;
            c.a_len   = enc_first.len;
            clr       = 1'b1;
            if (p_status_v) begin
              c.has_status = 1'b1;
              c.status     = p_status;
            end else begin
              c.b_bytes[0] = b;
              c.b_len      = 2'd1;
            end
          end
        end
        M_HIGH_BS: begin
          if (b == jsu_pkg::CH_U) begin
            mode_nxt   = M_HEX2;
            cnt_nxt    = 2'd0;
            second_nxt = 16'd0;
          end else begin
            c.a_bytes = enc_first.bytes;
            c.a_len   = enc_first.len;
            clr       = 1'b1;
            if (e_byte_v) begin
              c.b_bytes[0] = e_byte;
              c.b_len      = 2'd1;
            end else begin
              c.has_status = 1'b1;
              c.status     = jsu_pkg::ST_BADESC;
            end
          end
        end
        M_HEX2: begin
          if (!hx[4]) begin
            c.a_bytes    = enc_first.bytes;
            c.a_len      = enc_first.len;
            c.has_status = 1'b1;
            c.status     = jsu_pkg::ST_BADU;
            clr          = 1'b1;
          end else if (cnt_r == 2'd3) begin
            if (acc2_low) begin
              c.a_bytes = enc_join.bytes;
              c.a_len   = enc_join.len;
              clr       = 1'b1;
            end else begin
              c.a_bytes = enc_first.bytes;
              c.a_len   = enc_first.len;
              if (acc2_high) begin
                first_nxt  = acc2;
                mode_nxt   = M_HIGH;
                cnt_nxt    = 2'd0;
                second_nxt = 16'd0;
              end else begin
                c.b_bytes = enc_acc2.bytes[2:0];
                c.b_len   = enc_acc2.len[1:0];
                clr       = 1'b1;
              end
            end
          end else begin
            second_nxt = acc2;
            cnt_nxt    = cnt_r + 2'd1;
          end
        end
        default: begin
          mode_nxt = M_PLAIN;
          if (p_status_v) begin
            c.has_status = 1'b1;
            c.status     = p_status;
            clr          = 1'b1;
          end else if (p_to_esc) begin
            mode_nxt = M_ESC;
          end else begin
            c.a_bytes[0] = b;
            c.a_len      = 3'd1;
          end
        end
      endcase
    end
    if (clr) begin
      mode_nxt   = M_PLAIN;
      cnt_nxt    = 2'd0;
      first_nxt  = 16'd0;
      second_nxt = 16'd0;
    end
  end

  assign cmd  = c;
  assign push = accept && ((c.a_len != 3'd0) || (c.b_len != 2'd0) || c.has_status);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_PLAIN;
      cnt_r    <= 2'd0;
      first_r  <= 16'd0;
      second_r <= 16'd0;
    end else if (accept) begin
      mode_r   <= mode_nxt;
      cnt_r    <= cnt_nxt;
      first_r  <= first_nxt;
      second_r <= second_nxt;
    end
  end

  `JSU_ASSERT(a_status_clears, (push && cmd.has_status) |=> (mode_r == M_PLAIN && cnt_r == 2'd0 && first_r == 16'd0), "state not cleared after status")
  `JSU_ASSERT(a_push_only_on_accept, push |-> (in_valid && !q_full), "push without accepted request")
  `JSU_ASSERT(a_high_held, (mode_r == M_HIGH) |-> (first_r >= jsu_pkg::SURR_HI_MIN && first_r <= jsu_pkg::SURR_HI_MAX), "held unit not a high surrogate")

endmodule

@@ rtl/jsu_queue.sv @@
`include "json_string_unescape_utf8_unit_defines.svh"

module jsu_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  jsu_pkg::cmd_t push_data,
  input  logic          pop,
  output logic          full,
  output logic          head_valid,
  output jsu_pkg::cmd_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  jsu_pkg::cmd_t mem [DEPTH];
  logic [PW-1:0] wr_r, rd_r;
  logic [CW-1:0] count_r;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wr_r <= ptr_inc(wr_r);
      end
      if (pop) begin
        rd_r <= ptr_inc(rd_r);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  `JSU_ASSERT(a_no_overflow, full |-> !push, "push into full queue")
  `JSU_ASSERT(a_no_underflow, !head_valid |-> !pop, "pop from empty queue")
  `JSU_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> (count_r == '0), "queue not empty after reset")

endmodule

@@ rtl/jsu_back.sv @@
module jsu_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  jsu_pkg::cmd_t     head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output jsu_pkg::out_req_t out_data
);

  logic [2:0]        pos_r;
  logic [3:0]        total;
  logic [2:0]        bidx;
  logic              load;
  logic              is_last;
  jsu_pkg::out_req_t res;
  logic              out_valid_r;
  jsu_pkg::out_req_t out_data_r;

  assign total   = {1'b0, head.a_len} + {2'b0, head.b_len} + {3'b0, head.has_status};
  assign bidx    = pos_r - head.a_len;
  assign is_last = ({1'b0, pos_r} == (total - 4'd1));
  assign load    = head_valid && (!out_valid_r || out_ready);
  assign pop     = load && is_last;

  always_comb begin
    res      = '0;
    res.last = is_last;
    if (pos_r < head.a_len) begin
      res.out_byte = head.a_bytes[pos_r[1:0]];
      res.status   = jsu_pkg::ST_BYTE;
    end else if (bidx < {1'b0, head.b_len}) begin
      res.out_byte = head.b_bytes[bidx[1:0]];
      res.status   = jsu_pkg::ST_BYTE;
    end else begin
      res.out_byte = 8'd0;
      res.status   = head.status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pos_r       <= 3'd0;
    end else if (load) begin
      out_valid_r <= 1'b1;
      pos_r       <= is_last ? 3'd0 : pos_r + 3'd1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ rtl/json_string_unescape_utf8_unit.sv @@
// JSON string body unescaper with UTF-8 output.
// in_data carries one body byte per request (or an end-of-input mark),
// starting after the opening quote; in_valid/in_ready handshake it.
// out_data carries one result per transfer: a UTF-8 byte with status zero,
// or a status that ends the string (done, unterminated, bad escape,
// bad \u escape, control byte); last marks the final result of a request.
// A request's first result reaches out_data through the command queue and
// then the output register. Input is taken every cycle while the command
// queue of QUEUE_DEPTH entries has room; the output side delivers one
// result per cycle while out_ready is high, so a request with k results
// takes k output transfers (up to six for a broken surrogate pair followed
// by another \u escape). Requests such as a backslash or a hex digit give
// no result at all. Reset clears the decoder to plain mode, empties the
// queue and drops out_valid. When the receiver stalls, the output register
// holds its result, the queue fills, and in_ready falls once it is full.
module json_string_unescape_utf8_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  jsu_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output jsu_pkg::out_req_t out_data
);

  logic          q_full, q_push, q_pop, q_head_valid;
  jsu_pkg::cmd_t q_push_data, q_head;

  jsu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_ready (in_ready),
    .q_full   (q_full),
    .push     (q_push),
    .cmd      (q_push_data)
  );

  jsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_push_data),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  jsu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule
